/* design/btoa_pkg.sv */
// Shared format codes, flag type and character helpers for the number-to-text unit.
package btoa_pkg;

	// Format codes carried on req_type.
	localparam logic [1:0] FMT_SIGNED   = 2'd0;
	localparam logic [1:0] FMT_UNSIGNED = 2'd1;
	localparam logic [1:0] FMT_HEX      = 2'd2;
	localparam logic [1:0] FMT_RESERVED = 2'd3;

	localparam logic [6:0] ASCII_ZERO  = 7'h30;
	localparam logic [6:0] ASCII_ALPHA = 7'h57; // 'a' minus ten
	localparam logic [6:0] ASCII_MINUS = 7'h2d;

	// Per-number flags that travel with the magnitude through the queue.
	typedef struct packed {
		logic neg;
		logic hex;
	} btoa_flags_t;

	function automatic logic [6:0] digit_char(input logic [3:0] d);
		logic [6:0] c;
		if (d < 4'd10) begin
			c = ASCII_ZERO + {3'b000, d};
		end else begin
			c = ASCII_ALPHA + {3'b000, d};
		end
		return c;
	endfunction

endpackage

/* design/binary_to_ascii_number_unit.sv */
// Top level of the binary word to ASCII number text converter.
//
//  channel  direction  handshake              payload
//  num      in         num_valid / num_ready  value[31:0], req_type[1:0]
//  chr      out        chr_valid / chr_ready  ascii_char[6:0], last_char
//
// A decimal number leaves the queue, has every bit of the word shifted through the
// shift-and-add-three loop, drops its leading zero digits one at a time and then
// streams its characters, a minus sign first if it is negative.
// Hex numbers skip the BCD loop.
// Reset empties the queue and the output register; the front keeps taking
// numbers while the back end is busy or the output is stalled, up to two.
module binary_to_ascii_number_unit #(
	parameter int WORD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        num_valid,
	output logic        num_ready,
	input  logic [31:0] value,
	input  logic [1:0]  req_type,
	output logic        chr_valid,
	input  logic        chr_ready,
	output logic [6:0]  ascii_char,
	output logic        last_char
);
	import btoa_pkg::*;

	// Each queue entry holds the magnitude and the flags that decide how it prints.
	localparam int ENTRY_BITS = WORD_BITS + $bits(btoa_flags_t);

	logic                  q_full;
	logic                  q_push;
	logic                  q_pop;
	logic                  q_nonempty;
	logic [WORD_BITS-1:0]  front_mag;
	btoa_flags_t           front_flags;
	logic [ENTRY_BITS-1:0] q_rdata;
	logic [WORD_BITS-1:0]  back_mag;
	btoa_flags_t           back_flags;

	// The front end decodes the format and negates signed negative words at once.
	btoa_front #(
		.WORD_BITS (WORD_BITS)
	) u_front (
		.num_valid (num_valid),
		.num_ready (num_ready),
		.value     (value),
		.req_type  (req_type),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_mag     (front_mag),
		.q_flags   (front_flags)
	);

	btoa_queue #(
		.DATA_BITS (ENTRY_BITS)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wdata    ({front_flags, front_mag}),
		.full     (q_full),
		.pop      (q_pop),
		.rdata    (q_rdata),
		.nonempty (q_nonempty)
	);

	assign back_mag   = q_rdata[WORD_BITS-1:0];
	assign back_flags = q_rdata[ENTRY_BITS-1:WORD_BITS];

	// The back end converts one number at a time and streams its characters,
	// holding each in an output register until the transaction completes.
	btoa_back #(
		.WORD_BITS (WORD_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_pop      (q_pop),
		.q_mag      (back_mag),
		.q_flags    (back_flags),
		.chr_valid  (chr_valid),
		.chr_ready  (chr_ready),
		.ascii_char (ascii_char),
		.last_char  (last_char)
	);

endmodule

/* design/btoa_front.sv */
// Front end: accepts numbers, decodes the format and forms the magnitude.
module btoa_front #(
	parameter int WORD_BITS = 32
) (
	input  logic                  num_valid,
	output logic                  num_ready,
	input  logic [31:0]           value,
	input  logic [1:0]            req_type,
	input  logic                  q_full,
	output logic                  q_push,
	output logic [WORD_BITS-1:0]  q_mag,
	output btoa_pkg::btoa_flags_t q_flags
);
	import btoa_pkg::*;

	logic [WORD_BITS+31:0] value_ext;
	logic [WORD_BITS-1:0]  word;
	logic                  is_signed;
	logic                  is_neg;

	assign value_ext = {{WORD_BITS{1'b0}}, value};
	assign word      = value_ext[WORD_BITS-1:0];
	assign is_signed = (req_type == FMT_SIGNED);
	assign is_neg    = is_signed && word[WORD_BITS-1];

	// Two's complement negation also yields the most negative value's true magnitude.
	assign q_mag         = is_neg ? WORD_BITS'(~word + WORD_BITS'(1)) : word;
	assign q_flags.neg   = is_neg;
	assign q_flags.hex   = (req_type == FMT_HEX) || (req_type == FMT_RESERVED);

	assign num_ready = !q_full;
	assign q_push    = num_valid && !q_full;

endmodule

/* design/btoa_queue.sv */
// Two-entry queue between the front end and the conversion engine.
module btoa_queue #(
	parameter int DATA_BITS = 34
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [DATA_BITS-1:0] wdata,
	output logic                 full,
	input  logic                 pop,
	output logic [DATA_BITS-1:0] rdata,
	output logic                 nonempty
);
	logic [DATA_BITS-1:0] mem_q [2];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           count_q;

	assign full     = (count_q == 2'd2);
	assign nonempty = (count_q != 2'd0);
	assign rdata    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

/* design/btoa_back.sv */
// Back end: binary to BCD conversion, leading zero removal and character output.
module btoa_back #(
	parameter int WORD_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_nonempty,
	output logic                  q_pop,
	input  logic [WORD_BITS-1:0]  q_mag,
	input  btoa_pkg::btoa_flags_t q_flags,
	output logic                  chr_valid,
	input  logic                  chr_ready,
	output logic [6:0]            ascii_char,
	output logic                  last_char
);
	import btoa_pkg::*;

	localparam int DEC_DIGITS = (WORD_BITS * 30103) / 100000 + 1;
	localparam int HEX_DIGITS = (WORD_BITS + 3) / 4;
	localparam int NUM_DIGITS = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
	localparam int DIG_BITS   = NUM_DIGITS * 4;
	localparam int CNT_BITS   = $clog2(WORD_BITS + 1);
	localparam int REM_BITS   = $clog2(NUM_DIGITS + 1);

	typedef enum logic [1:0] {
		B_IDLE,
		B_CONV,
		B_SKIP,
		B_EMIT
	} back_state_t;

	back_state_t          state_q;
	logic [WORD_BITS-1:0] sh_q;
	logic [DIG_BITS-1:0]  dig_q;
	logic [DIG_BITS-1:0]  dig_adj;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [REM_BITS-1:0]  rem_q;
	logic                 neg_q;
	logic                 out_valid_q;
	logic [6:0]           char_q;
	logic                 last_q;
	logic [3:0]           top_digit;
	logic                 out_load;

	assign top_digit = dig_q[DIG_BITS-1 -: 4];
	assign out_load  = !out_valid_q || chr_ready;
	assign q_pop     = (state_q == B_IDLE) && q_nonempty;

	assign chr_valid  = out_valid_q;
	assign ascii_char = char_q;
	assign last_char  = last_q;

	// Add-three correction on every BCD digit ahead of each shift.
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (dig_q[i*4 +: 4] >= 4'd5) begin
				dig_adj[i*4 +: 4] = dig_q[i*4 +: 4] + 4'd3;
			end else begin
				dig_adj[i*4 +: 4] = dig_q[i*4 +: 4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
			neg_q       <= 1'b0;
			cnt_q       <= '0;
			rem_q       <= '0;
			sh_q        <= '0;
			dig_q       <= '0;
			char_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			// In the emit state the output register is refilled instead.
			if (out_valid_q && chr_ready && (state_q != B_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (q_nonempty) begin
						neg_q <= q_flags.neg;
						sh_q  <= q_mag;
						rem_q <= REM_BITS'(NUM_DIGITS);
						cnt_q <= CNT_BITS'(WORD_BITS);
						if (q_flags.hex) begin
							dig_q   <= DIG_BITS'(q_mag);
							state_q <= B_SKIP;
						end else begin
							dig_q   <= '0;
							state_q <= B_CONV;
						end
					end
				end
				B_CONV: begin
					dig_q <= {dig_adj[DIG_BITS-2:0], sh_q[WORD_BITS-1]};
					sh_q  <= sh_q << 1;
					cnt_q <= cnt_q - CNT_BITS'(1);
					if (cnt_q == CNT_BITS'(1)) begin
						state_q <= B_SKIP;
					end
				end
				B_SKIP: begin
					// The last digit is always kept, so zero prints as one '0'.
					if ((top_digit == 4'd0) && (rem_q != REM_BITS'(1))) begin
						dig_q <= dig_q << 4;
						rem_q <= rem_q - REM_BITS'(1);
					end else begin
						state_q <= B_EMIT;
					end
				end
				B_EMIT: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						if (neg_q) begin
							char_q <= ASCII_MINUS;
							last_q <= 1'b0;
							neg_q  <= 1'b0;
						end else begin
							char_q <= digit_char(top_digit);
							last_q <= (rem_q == REM_BITS'(1));
							dig_q  <= dig_q << 4;
							rem_q  <= rem_q - REM_BITS'(1);
							if (rem_q == REM_BITS'(1)) begin
								state_q <= B_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule
